[rtl/rc4sc_pkg.sv]
// Package for the RC4 engine: microcode format, control structs and program ROM.
package rc4sc_pkg;

  localparam int unsigned MAX_KEY_BYTES_DEF = 256;
  localparam int unsigned SBOX_DEPTH        = 256;
  localparam int unsigned UPC_W             = 5;

  // S-box read address select
  typedef enum logic [1:0] {
    RA_N,
    RA_INEXT,
    RA_J,
    RA_ACC
  } sb_raddr_e;

  // S-box write select
  typedef enum logic [2:0] {
    WR_NONE,
    WR_INIT,
    WR_N_RD,
    WR_ACC_TA,
    WR_I_RD,
    WR_J_TA
  } sb_wr_e;

  // Register operations of the datapath
  typedef enum logic [3:0] {
    OP_NONE,
    OP_KEY_LOAD,
    OP_INIT_NEXT,
    OP_KS_ACC,
    OP_KS_NEXT,
    OP_SCHED_END,
    OP_GEN_I,
    OP_GEN_J,
    OP_GEN_T,
    OP_EMIT
  } dp_op_e;

  // Sequencer branch conditions
  typedef enum logic [2:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_DISPATCH,
    JC_NLAST,
    JC_MORE,
    JC_NSCHED,
    JC_OUT_WAIT
  } jump_e;

  typedef struct packed {
    sb_raddr_e        rd;
    sb_wr_e           wr;
    dp_op_e           op;
    jump_e            jmp;
    logic [UPC_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    ctrl_word_t cw;
    logic       accept;
  } ctrl_t;

  typedef struct packed {
    logic n_last;
    logic sched;
    logic last;
    logic out_free;
  } status_t;

  // Program addresses
  localparam logic [UPC_W-1:0] ST_IDLE  = 5'd0;
  localparam logic [UPC_W-1:0] ST_KEY   = 5'd1;
  localparam logic [UPC_W-1:0] ST_INIT  = 5'd2;
  localparam logic [UPC_W-1:0] ST_CHK   = 5'd3;
  localparam logic [UPC_W-1:0] ST_KS0   = 5'd4;
  localparam logic [UPC_W-1:0] ST_KS1   = 5'd5;
  localparam logic [UPC_W-1:0] ST_KS2   = 5'd6;
  localparam logic [UPC_W-1:0] ST_KS3   = 5'd7;
  localparam logic [UPC_W-1:0] ST_KS4   = 5'd8;
  localparam logic [UPC_W-1:0] ST_KSEND = 5'd9;
  localparam logic [UPC_W-1:0] ST_GEN0  = 5'd10;
  localparam logic [UPC_W-1:0] ST_GEN1  = 5'd11;
  localparam logic [UPC_W-1:0] ST_GEN2  = 5'd12;
  localparam logic [UPC_W-1:0] ST_GEN3  = 5'd13;
  localparam logic [UPC_W-1:0] ST_GEN4  = 5'd14;
  localparam logic [UPC_W-1:0] ST_GEN5  = 5'd15;
  localparam logic [UPC_W-1:0] ST_GEN6  = 5'd16;

  function automatic ctrl_word_t cw_make(input sb_raddr_e rd, input sb_wr_e wr,
                                         input dp_op_e op, input jump_e jmp,
                                         input logic [UPC_W-1:0] target);
    ctrl_word_t cw;
    cw.rd     = rd;
    cw.wr     = wr;
    cw.op     = op;
    cw.jmp    = jmp;
    cw.target = target;
    return cw;
  endfunction

  function automatic ctrl_word_t ucode_rom(input logic [UPC_W-1:0] addr);
    ctrl_word_t cw;
    unique case (addr)
      ST_IDLE:  cw = cw_make(RA_N,     WR_NONE,   OP_NONE,      JC_DISPATCH, ST_GEN0);
      ST_KEY:   cw = cw_make(RA_N,     WR_NONE,   OP_KEY_LOAD,  JC_NLAST,    ST_IDLE);
      ST_INIT:  cw = cw_make(RA_N,     WR_INIT,   OP_INIT_NEXT, JC_MORE,     ST_INIT);
      ST_CHK:   cw = cw_make(RA_N,     WR_NONE,   OP_NONE,      JC_NSCHED,   ST_IDLE);
      ST_KS0:   cw = cw_make(RA_N,     WR_NONE,   OP_NONE,      JC_NEXT,     ST_IDLE);
      ST_KS1:   cw = cw_make(RA_N,     WR_NONE,   OP_KS_ACC,    JC_NEXT,     ST_IDLE);
      ST_KS2:   cw = cw_make(RA_ACC,   WR_NONE,   OP_NONE,      JC_NEXT,     ST_IDLE);
      ST_KS3:   cw = cw_make(RA_N,     WR_N_RD,   OP_NONE,      JC_NEXT,     ST_IDLE);
      ST_KS4:   cw = cw_make(RA_N,     WR_ACC_TA, OP_KS_NEXT,   JC_MORE,     ST_KS0);
      ST_KSEND: cw = cw_make(RA_N,     WR_NONE,   OP_SCHED_END, JC_ALWAYS,   ST_IDLE);
      ST_GEN0:  cw = cw_make(RA_INEXT, WR_NONE,   OP_GEN_I,     JC_NEXT,     ST_IDLE);
      ST_GEN1:  cw = cw_make(RA_N,     WR_NONE,   OP_GEN_J,     JC_NEXT,     ST_IDLE);
      ST_GEN2:  cw = cw_make(RA_J,     WR_NONE,   OP_NONE,      JC_NEXT,     ST_IDLE);
      ST_GEN3:  cw = cw_make(RA_N,     WR_I_RD,   OP_GEN_T,     JC_NEXT,     ST_IDLE);
      ST_GEN4:  cw = cw_make(RA_N,     WR_J_TA,   OP_NONE,      JC_NEXT,     ST_IDLE);
      ST_GEN5:  cw = cw_make(RA_ACC,   WR_NONE,   OP_NONE,      JC_NEXT,     ST_IDLE);
      ST_GEN6:  cw = cw_make(RA_ACC,   WR_NONE,   OP_EMIT,      JC_OUT_WAIT, ST_IDLE);
      default:  cw = cw_make(RA_N,     WR_NONE,   OP_NONE,      JC_ALWAYS,   ST_IDLE);
    endcase
    return cw;
  endfunction

endpackage

[rtl/rc4sc_sequencer.sv]
// Microcode sequencer: step counter, program ROM lookup and branch logic.
module rc4sc_sequencer
  import rc4sc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    mode_i,
  input  status_t status_i,
  output ctrl_t   ctrl_o,
  output logic    in_stall_o
);

  logic [UPC_W-1:0] upc_q, upc_d, upc_inc;
  ctrl_word_t       cw;
  logic             idle;

  assign cw      = ucode_rom(upc_q);
  assign upc_inc = upc_q + UPC_W'(1);
  assign idle    = (cw.jmp == JC_DISPATCH);

  always_comb begin
    upc_d = upc_inc;
    unique case (cw.jmp)
      JC_NEXT:     upc_d = upc_inc;
      JC_ALWAYS:   upc_d = cw.target;
      JC_DISPATCH: begin
        if (!in_valid_i) upc_d = upc_q;
        else if (mode_i) upc_d = cw.target;
        else upc_d = upc_inc;
      end
      JC_NLAST:    upc_d = status_i.last ? upc_inc : cw.target;
      JC_MORE:     upc_d = status_i.n_last ? upc_inc : cw.target;
      JC_NSCHED:   upc_d = status_i.sched ? upc_inc : cw.target;
      JC_OUT_WAIT: upc_d = status_i.out_free ? cw.target : upc_q;
      default:     upc_d = ST_IDLE;
    endcase
  end

  // Reset enters the identity fill of the S-box.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= ST_INIT;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign in_stall_o    = !idle;
  assign ctrl_o.cw     = cw;
  assign ctrl_o.accept = idle && in_valid_i;

endmodule

[rtl/rc4sc_datapath.sv]
// Datapath: S-box and key store memories, index registers and output register.
module rc4sc_datapath
  import rc4sc_pkg::*;
#(
  parameter int unsigned MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_t      ctrl_i,
  input  logic [7:0] value_i,
  input  logic       last_i,
  input  logic       out_stall_i,
  output status_t    status_o,
  output logic       out_valid_o,
  output logic [7:0] data_out_o
);

  localparam int unsigned KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int unsigned KLW = $clog2(MAX_KEY_BYTES + 1);

  logic [7:0]     sbox_mem [SBOX_DEPTH];
  logic [7:0]     key_mem  [MAX_KEY_BYTES];

  logic [7:0]     value_q, n_q, n_d, acc_q, acc_d, i_q, i_d, j_q, j_d, ta_q, ta_d;
  logic [7:0]     sb_rd_q, ks_rd_q, out_q, out_d;
  logic [KAW-1:0] kidx_q, kidx_d;
  logic [KLW-1:0] key_len_q, key_len_d, len_m1;
  logic           last_q, sched_q, sched_d, out_valid_q, out_valid_d;
  logic           sb_we, ks_we, out_free;
  logic [7:0]     sb_waddr, sb_wdata, sb_raddr;
  ctrl_word_t     cw;

  assign cw       = ctrl_i.cw;
  assign out_free = !out_valid_q || !out_stall_i;
  assign ks_we    = (cw.op == OP_KEY_LOAD) && (key_len_q < KLW'(MAX_KEY_BYTES));
  assign len_m1   = (key_len_q == '0) ? '0 : key_len_q - KLW'(1);

  always_comb begin
    unique case (cw.rd)
      RA_N:     sb_raddr = n_q;
      RA_INEXT: sb_raddr = i_q + 8'd1;
      RA_J:     sb_raddr = j_q;
      RA_ACC:   sb_raddr = acc_q;
      default:  sb_raddr = n_q;
    endcase
  end

  always_comb begin
    sb_we    = 1'b1;
    sb_waddr = n_q;
    sb_wdata = sb_rd_q;
    unique case (cw.wr)
      WR_NONE:   sb_we = 1'b0;
      WR_INIT:   sb_wdata = n_q;
      WR_N_RD:   sb_wdata = sb_rd_q;
      WR_ACC_TA: begin
        sb_waddr = acc_q;
        sb_wdata = ta_q;
      end
      WR_I_RD:   sb_waddr = i_q;
      WR_J_TA:   begin
        sb_waddr = j_q;
        sb_wdata = ta_q;
      end
      default:   sb_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (sb_we) sbox_mem[sb_waddr] <= sb_wdata;
    sb_rd_q <= sbox_mem[sb_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ks_we) key_mem[key_len_q[KAW-1:0]] <= value_q;
    ks_rd_q <= key_mem[kidx_q];
  end

  always_comb begin
    n_d         = n_q;
    acc_d       = acc_q;
    i_d         = i_q;
    j_d         = j_q;
    ta_d        = ta_q;
    kidx_d      = kidx_q;
    key_len_d   = key_len_q;
    sched_d     = sched_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_free;
    unique case (cw.op)
      OP_NONE:      ;
      OP_KEY_LOAD:  begin
        if (ks_we) key_len_d = key_len_q + KLW'(1);
        sched_d = last_q;
      end
      // Start the swap accumulator from zero; the generator reuses it
      OP_INIT_NEXT: begin
        n_d   = n_q + 8'd1;
        acc_d = '0;
      end
      OP_KS_ACC:    begin
        ta_d  = sb_rd_q;
        acc_d = acc_q + sb_rd_q + ks_rd_q;
      end
      OP_KS_NEXT:   begin
        n_d    = n_q + 8'd1;
        kidx_d = (KLW'(kidx_q) == len_m1) ? '0 : kidx_q + KAW'(1);
      end
      OP_SCHED_END: begin
        acc_d     = '0;
        i_d       = '0;
        j_d       = '0;
        kidx_d    = '0;
        key_len_d = '0;
        sched_d   = 1'b0;
      end
      OP_GEN_I:     i_d = i_q + 8'd1;
      OP_GEN_J:     begin
        ta_d = sb_rd_q;
        j_d  = j_q + sb_rd_q;
      end
      OP_GEN_T:     acc_d = ta_q + sb_rd_q;
      OP_EMIT:      begin
        if (out_free) begin
          out_d       = value_q ^ sb_rd_q;
          out_valid_d = 1'b1;
        end
      end
      default:      ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= '0;
      acc_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      kidx_q      <= '0;
      key_len_q   <= '0;
      sched_q     <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      n_q         <= n_d;
      acc_q       <= acc_d;
      i_q         <= i_d;
      j_q         <= j_d;
      kidx_q      <= kidx_d;
      key_len_q   <= key_len_d;
      sched_q     <= sched_d;
      out_valid_q <= out_valid_d;
      if (ctrl_i.accept) last_q <= last_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ta_q  <= ta_d;
    out_q <= out_d;
    if (ctrl_i.accept) value_q <= value_i;
  end

  assign status_o.n_last   = (n_q == 8'hFF);
  assign status_o.sched    = sched_q;
  assign status_o.last     = last_q;
  assign status_o.out_free = out_free;
  assign out_valid_o       = out_valid_q;
  assign data_out_o        = out_q;

endmodule

[rtl/rc4_stream_cipher.sv]
// Top level of the RC4 engine: microcode sequencer driving the S-box datapath.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------
//   input   | in        | in_valid_i / in_stall_o | mode_i, value_i, last_i
//   output  | out       | out_valid_o/out_stall_i | data_out_o
//
// A data word runs through steps GEN0 to GEN6, as the S-box has one read port
// with a registered read, and one keystream byte needs three dependent reads
// plus two swap writes. A key byte is stored by the KEY step; the final key byte
// then runs the key schedule (256 identity writes, then 256 swap steps, each
// through KS0 to KS4). After reset the S-box is filled with the identity, during
// which in_stall_o stays high. A stalled output word holds in its register; the
// engine waits on it only when the next result is ready.
module rc4_stream_cipher
  import rc4sc_pkg::*;
#(
  parameter int unsigned MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       mode_i,
  input  logic [7:0] value_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] data_out_o
);

  ctrl_t   ctrl;
  status_t status;

  // Program counter and branch logic; dispatch a word only from the idle step.
  rc4sc_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .status_i   (status),
    .ctrl_o     (ctrl),
    .in_stall_o (in_stall_o)
  );

  // S-box, key store, indices and the output register.
  rc4sc_datapath #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .value_i     (value_i),
    .last_i      (last_i),
    .out_stall_i (out_stall_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .data_out_o  (data_out_o)
  );

endmodule
